### hdl/sha1md_pkg.sv
// shared types and constants for the sha-1 message digest core
// used by sha1md_ctrl, sha1md_datapath and sha1_message_digest_core; no dependencies

package sha1md_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_PAD,
        ST_ROUND,
        ST_UPDATE,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        BSRC_DATA,
        BSRC_MARK,
        BSRC_ZERO,
        BSRC_LEN
    } bsrc_t;

    typedef enum logic [1:0] {
        PH_CH,
        PH_PAR1,
        PH_MAJ,
        PH_PAR2
    } phase_t;

    localparam int WORD_W   = 32;
    localparam int LEN_W    = 61;
    localparam int FILL_W   = 6;
    localparam int ROUND_W  = 7;
    localparam int NUM_H    = 5;

    localparam logic [2:0] MAX_COUNT  = 3'd4;
    localparam logic [2:0] LAST_INDEX = 3'd4;

    localparam logic [ROUND_W-1:0] ROUND_P1   = 7'd20;
    localparam logic [ROUND_W-1:0] ROUND_P2   = 7'd40;
    localparam logic [ROUND_W-1:0] ROUND_P3   = 7'd60;
    localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;

    localparam logic [FILL_W-1:0] FILL_LEN_START = 6'd55;
    localparam logic [FILL_W-1:0] FILL_BLOCK_END = 6'd63;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [WORD_W-1:0] K_CH   = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_PAR1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K_MAJ  = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K_PAR2 = 32'hCA62C1D6;

    localparam logic [NUM_H-1:0][WORD_W-1:0] H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    typedef struct packed {
        logic        load_word;
        logic        put_byte;
        bsrc_t       bsrc;
        logic [1:0]  byte_sel;
        logic        count_byte;
        logic        start_block;
        logic        round_en;
        phase_t      phase;
        logic        update_chain;
        logic        restart;
        logic [2:0]  out_sel;
    } cmd_t;

    typedef struct packed {
        logic fill_55;
        logic fill_63;
    } status_t;

endpackage

### hdl/sha1_message_digest_core.sv
// sha-1 message digest core, top level with stream ports and checks
// depends on sha1md_pkg, sha1md_ctrl and sha1md_datapath

// A message arrives as 32-bit big-endian words, each with a byte count of 0 to 4
// (larger counts act as 4) and tlast on the final transaction; five digest words
// H0..H4 come out after tlast, the fifth with tlast, and the core then starts a new
// message. After acceptance, the bytes of a transaction are packed one at a time;
// each 64-byte block is then compressed in the single round unit (80 rounds and
// one chaining update). The final transaction adds padding bytes (9 to 64, or 65
// to 72 with an extra block), each padded block is compressed the same way, and
// then the digest is read out. One transaction is in work at a time: tready
// is low from acceptance until its bytes are packed and any full block is
// compressed, and after a tlast transaction until the last digest word.

module sha1_message_digest_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // msg_word[31:0], byte_count[34:32], zero fill
    input  logic        s_axis_tlast,   // final_item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // digest_word[31:0], word_index[34:32], zero fill
    output logic        m_axis_tlast    // last_word
);

    sha1md_pkg::cmd_t              cmd;
    sha1md_pkg::status_t           stat;
    logic [sha1md_pkg::WORD_W-1:0] digest;

    sha1md_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_count  (s_axis_tdata[34:32]),
        .in_final  (s_axis_tlast),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_last  (m_axis_tlast),
        .cmd       (cmd)
    );

    sha1md_datapath u_datapath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_word (s_axis_tdata[31:0]),
        .cmd     (cmd),
        .stat    (stat),
        .digest  (digest)
    );

    assign m_axis_tdata = {5'b00000, cmd.out_sel, digest};

    // no input transaction while the digest is being read out
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted during digest readout");

    // the core is ready again right after the last digest word
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("core not idle after last digest word");

    // a completed block always goes straight into the rounds
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.put_byte && stat.fill_63) |=> cmd.round_en)
        else $error("full block not compressed");

    // the tlast word carries index four
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[34:32] == sha1md_pkg::LAST_INDEX))
        else $error("last digest word has wrong index");

endmodule

### hdl/sha1md_datapath.sv
// sha-1 datapath: byte packer, 16-word schedule window, round unit, chaining words
// depends on sha1md_pkg

module sha1md_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [sha1md_pkg::WORD_W-1:0]     in_word,
    input  sha1md_pkg::cmd_t                  cmd,
    output sha1md_pkg::status_t               stat,
    output logic [sha1md_pkg::WORD_W-1:0]     digest
);

    logic [sha1md_pkg::WORD_W-1:0] word_reg;
    logic [sha1md_pkg::WORD_W-1:0] acc_reg;
    logic [sha1md_pkg::WORD_W-1:0] acc_next;
    logic [sha1md_pkg::WORD_W-1:0] win_reg [16];
    logic [sha1md_pkg::WORD_W-1:0] vars_reg [sha1md_pkg::NUM_H];
    logic [sha1md_pkg::WORD_W-1:0] chain_reg [sha1md_pkg::NUM_H];
    logic [sha1md_pkg::FILL_W-1:0] fill_reg;
    logic [sha1md_pkg::LEN_W-1:0]  len_reg;

    logic [7:0]                    data_byte;
    logic [7:0]                    sel_byte;
    logic [63:0]                   len_shift;
    logic [sha1md_pkg::WORD_W-1:0] sched_w;
    logic [sha1md_pkg::WORD_W-1:0] f_val;
    logic [sha1md_pkg::WORD_W-1:0] k_val;
    logic [sha1md_pkg::WORD_W-1:0] tmp;
    logic [sha1md_pkg::WORD_W-1:0] va, vb, vc, vd, ve;

    assign va = vars_reg[0];
    assign vb = vars_reg[1];
    assign vc = vars_reg[2];
    assign vd = vars_reg[3];
    assign ve = vars_reg[4];

    always_comb
    begin
        case (cmd.byte_sel)
            2'd0:    data_byte = word_reg[31:24];
            2'd1:    data_byte = word_reg[23:16];
            2'd2:    data_byte = word_reg[15:8];
            default: data_byte = word_reg[7:0];
        endcase
    end

    // length in bits, big-endian byte picked by the low fill bits
    assign len_shift = {len_reg, 3'b000} << {fill_reg[2:0], 3'b000};

    always_comb
    begin
        unique case (cmd.bsrc)
            sha1md_pkg::BSRC_DATA: sel_byte = data_byte;
            sha1md_pkg::BSRC_MARK: sel_byte = sha1md_pkg::PAD_MARK;
            sha1md_pkg::BSRC_ZERO: sel_byte = 8'h00;
            sha1md_pkg::BSRC_LEN:  sel_byte = len_shift[63:56];
            default:               sel_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        acc_next = acc_reg;
        case (fill_reg[1:0])
            2'd0:    acc_next[31:24] = sel_byte;
            2'd1:    acc_next[23:16] = sel_byte;
            2'd2:    acc_next[15:8]  = sel_byte;
            default: acc_next[7:0]   = sel_byte;
        endcase
    end

    assign sched_w = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];

    always_comb
    begin
        unique case (cmd.phase)
            sha1md_pkg::PH_CH:
            begin
                f_val = vd ^ (vb & (vc ^ vd));
                k_val = sha1md_pkg::K_CH;
            end
            sha1md_pkg::PH_PAR1:
            begin
                f_val = vb ^ vc ^ vd;
                k_val = sha1md_pkg::K_PAR1;
            end
            sha1md_pkg::PH_MAJ:
            begin
                f_val = (vb & vc) | (vd & (vb | vc));
                k_val = sha1md_pkg::K_MAJ;
            end
            default:
            begin
                f_val = vb ^ vc ^ vd;
                k_val = sha1md_pkg::K_PAR2;
            end
        endcase
    end

    assign tmp = {va[26:0], va[31:27]} + f_val + ve + k_val + win_reg[0];

    always_ff @(posedge clk)
    begin
        if (cmd.load_word)
        begin
            word_reg <= in_word;
        end
        if (cmd.put_byte)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.put_byte && (fill_reg[1:0] == 2'd3))
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= acc_next;
        end
        else if (cmd.round_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= {sched_w[30:0], sched_w[31]};
        end
        if (cmd.start_block)
        begin
            for (int i = 0; i < sha1md_pkg::NUM_H; i++)
            begin
                vars_reg[i] <= chain_reg[i];
            end
        end
        else if (cmd.round_en)
        begin
            vars_reg[0] <= tmp;
            vars_reg[1] <= va;
            vars_reg[2] <= {vb[1:0], vb[31:2]};
            vars_reg[3] <= vc;
            vars_reg[4] <= vd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            len_reg  <= '0;
            for (int i = 0; i < sha1md_pkg::NUM_H; i++)
            begin
                chain_reg[i] <= sha1md_pkg::H_INIT[i];
            end
        end
        else
        begin
            if (cmd.put_byte)
            begin
                fill_reg <= fill_reg + 6'd1;
            end
            if (cmd.restart)
            begin
                len_reg <= '0;
            end
            else if (cmd.count_byte)
            begin
                len_reg <= len_reg + 61'd1;
            end
            if (cmd.restart)
            begin
                for (int i = 0; i < sha1md_pkg::NUM_H; i++)
                begin
                    chain_reg[i] <= sha1md_pkg::H_INIT[i];
                end
            end
            else if (cmd.update_chain)
            begin
                for (int i = 0; i < sha1md_pkg::NUM_H; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + vars_reg[i];
                end
            end
        end
    end

    always_comb
    begin
        case (cmd.out_sel)
            3'd0:    digest = chain_reg[0];
            3'd1:    digest = chain_reg[1];
            3'd2:    digest = chain_reg[2];
            3'd3:    digest = chain_reg[3];
            default: digest = chain_reg[4];
        endcase
    end

    assign stat.fill_55 = (fill_reg == sha1md_pkg::FILL_LEN_START);
    assign stat.fill_63 = (fill_reg == sha1md_pkg::FILL_BLOCK_END);

endmodule

### hdl/sha1md_ctrl.sv
// sha-1 controller: byte feed, padding sequence, round counter and digest readout
// depends on sha1md_pkg

module sha1md_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [2:0]           in_count,
    input  logic                 in_final,
    input  logic                 out_ready,
    input  sha1md_pkg::status_t  stat,
    output logic                 in_ready,
    output logic                 out_valid,
    output logic                 out_last,
    output sha1md_pkg::cmd_t     cmd
);

    sha1md_pkg::state_t state_reg, state_next;
    sha1md_pkg::state_t resume_reg, resume_next;
    logic [1:0]                     byte_idx_reg, byte_idx_next;
    logic [2:0]                     count_reg, count_next;
    logic                           final_reg, final_next;
    logic [sha1md_pkg::ROUND_W-1:0] round_reg, round_next;
    logic                           mark_reg, mark_next;
    logic                           lenph_reg, lenph_next;
    logic [2:0]                     out_idx_reg, out_idx_next;

    logic                           accept;
    logic                           last_byte;
    logic [2:0]                     count_clamped;
    sha1md_pkg::state_t             after_load;

    assign accept        = in_valid && (state_reg == sha1md_pkg::ST_IDLE);
    assign count_clamped = in_count[2] ? sha1md_pkg::MAX_COUNT : in_count;
    assign last_byte     = ({1'b0, byte_idx_reg} + 3'd1) == count_reg;
    assign after_load    = !last_byte ? sha1md_pkg::ST_LOAD :
                           (final_reg ? sha1md_pkg::ST_PAD : sha1md_pkg::ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        resume_next   = resume_reg;
        byte_idx_next = byte_idx_reg;
        count_next    = count_reg;
        final_next    = final_reg;
        round_next    = round_reg;
        mark_next     = mark_reg;
        lenph_next    = lenph_reg;
        out_idx_next  = out_idx_reg;
        unique case (state_reg)
            sha1md_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    count_next    = count_clamped;
                    final_next    = in_final;
                    byte_idx_next = 2'd0;
                    mark_next     = 1'b1;
                    lenph_next    = 1'b0;
                    if (count_clamped != 3'd0)
                    begin
                        state_next = sha1md_pkg::ST_LOAD;
                    end
                    else if (in_final)
                    begin
                        state_next = sha1md_pkg::ST_PAD;
                    end
                end
            end
            sha1md_pkg::ST_LOAD:
            begin
                byte_idx_next = byte_idx_reg + 2'd1;
                if (stat.fill_63)
                begin
                    state_next  = sha1md_pkg::ST_ROUND;
                    resume_next = after_load;
                end
                else
                begin
                    state_next = after_load;
                end
            end
            sha1md_pkg::ST_PAD:
            begin
                mark_next = 1'b0;
                if (!lenph_reg && stat.fill_55)
                begin
                    lenph_next = 1'b1;
                end
                if (stat.fill_63)
                begin
                    state_next  = sha1md_pkg::ST_ROUND;
                    resume_next = lenph_reg ? sha1md_pkg::ST_OUT : sha1md_pkg::ST_PAD;
                end
            end
            sha1md_pkg::ST_ROUND:
            begin
                if (round_reg == sha1md_pkg::ROUND_LAST)
                begin
                    round_next = '0;
                    state_next = sha1md_pkg::ST_UPDATE;
                end
                else
                begin
                    round_next = round_reg + 7'd1;
                end
            end
            sha1md_pkg::ST_UPDATE:
            begin
                out_idx_next = 3'd0;
                state_next   = resume_reg;
            end
            sha1md_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    if (out_idx_reg == sha1md_pkg::LAST_INDEX)
                    begin
                        state_next = sha1md_pkg::ST_IDLE;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = sha1md_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.bsrc      = sha1md_pkg::BSRC_DATA;
        cmd.phase     = sha1md_pkg::PH_CH;
        cmd.byte_sel  = byte_idx_reg;
        cmd.out_sel   = out_idx_reg;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        out_last      = 1'b0;
        unique case (state_reg)
            sha1md_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_word = accept;
            end
            sha1md_pkg::ST_LOAD:
            begin
                cmd.put_byte    = 1'b1;
                cmd.count_byte  = 1'b1;
                cmd.start_block = stat.fill_63;
            end
            sha1md_pkg::ST_PAD:
            begin
                cmd.put_byte    = 1'b1;
                cmd.start_block = stat.fill_63;
                if (mark_reg)
                begin
                    cmd.bsrc = sha1md_pkg::BSRC_MARK;
                end
                else if (lenph_reg)
                begin
                    cmd.bsrc = sha1md_pkg::BSRC_LEN;
                end
                else
                begin
                    cmd.bsrc = sha1md_pkg::BSRC_ZERO;
                end
            end
            sha1md_pkg::ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                if (round_reg < sha1md_pkg::ROUND_P1)
                begin
                    cmd.phase = sha1md_pkg::PH_CH;
                end
                else if (round_reg < sha1md_pkg::ROUND_P2)
                begin
                    cmd.phase = sha1md_pkg::PH_PAR1;
                end
                else if (round_reg < sha1md_pkg::ROUND_P3)
                begin
                    cmd.phase = sha1md_pkg::PH_MAJ;
                end
                else
                begin
                    cmd.phase = sha1md_pkg::PH_PAR2;
                end
            end
            sha1md_pkg::ST_UPDATE:
            begin
                cmd.update_chain = 1'b1;
            end
            sha1md_pkg::ST_OUT:
            begin
                out_valid   = 1'b1;
                out_last    = (out_idx_reg == sha1md_pkg::LAST_INDEX);
                cmd.restart = out_ready && out_last;
            end
            default:
            begin
                cmd.restart = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sha1md_pkg::ST_IDLE;
            resume_reg   <= sha1md_pkg::ST_IDLE;
            byte_idx_reg <= '0;
            count_reg    <= '0;
            final_reg    <= 1'b0;
            round_reg    <= '0;
            mark_reg     <= 1'b0;
            lenph_reg    <= 1'b0;
            out_idx_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            resume_reg   <= resume_next;
            byte_idx_reg <= byte_idx_next;
            count_reg    <= count_next;
            final_reg    <= final_next;
            round_reg    <= round_next;
            mark_reg     <= mark_next;
            lenph_reg    <= lenph_next;
            out_idx_reg  <= out_idx_next;
        end
    end

endmodule
